>>> design/rws_pkg.sv
package rws_pkg;

  localparam int MaxPop = 64;
  localparam int IdxW   = 6;
  localparam int CntW   = 7;
  localparam int FitW   = 32;
  localparam int RawW   = 39;
  localparam int TotW   = 38;
  localparam int DrawW  = 10;
  localparam int ProdW  = 48;
  localparam int AccW   = 42;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_DRAW  = 2'd2
  } cmd_t;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_EMPTY = 1'b1
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_TOTAL = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

endpackage

>>> design/rws_if.sv
interface rws_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       command;
  logic signed [rws_pkg::FitW-1:0]  fitness_value;
  logic [rws_pkg::DrawW-1:0]        draw_value;

  modport source (output valid, command, fitness_value, draw_value, input ready);
  modport sink   (input valid, command, fitness_value, draw_value, output ready);
endinterface

interface rws_out_if;
  logic                       valid;
  logic                       ready;
  logic [rws_pkg::IdxW-1:0]   selected_index;
  logic                       status;

  modport source (output valid, selected_index, status, input ready);
  modport sink   (input valid, selected_index, status, output ready);
endinterface

>>> design/roulette_wheel_selector_unit.sv
// Fitness-proportional (roulette wheel) selector. Clear and load requests complete in
// the idle state; loads append a signed Q16.16 fitness to a 64-entry table (loads into
// a full table are dropped). A draw request (draw_value in thousandths) returns one
// result: the first index whose fitness prefix, shifted up by the magnitude of the
// most negative loaded value, times 1000 exceeds draw times the shifted total; draws
// past the end pick the last entry, and an empty table or zero total gives index 0
// with status 1. A draw first forms the total (ST_TOTAL) and the scaled draw
// (ST_SCALE), then the walk reads the fitness store one entry per cycle through the
// read register and the accumulator, then ST_EMIT hands the result to the output
// register once it is free. The next request is taken once the result sits in the
// output register.
module roulette_wheel_selector_unit (
  input  logic            clk,
  input  logic            rst_n,
  rws_in_if.sink          in_req,
  rws_out_if.source       out_res
);

  rws_pkg::state_t                   state_r, state_nxt;

  logic [rws_pkg::CntW-1:0]          count_r;
  logic signed [rws_pkg::FitW-1:0]   lowest_r;
  logic [rws_pkg::RawW-1:0]          raw_r;

  logic [rws_pkg::FitW-1:0]          fit_mem [rws_pkg::MaxPop];
  logic [rws_pkg::FitW-1:0]          rdata_r;

  logic [rws_pkg::DrawW-1:0]         draw_r;
  logic [rws_pkg::TotW-1:0]          total_r;
  logic [rws_pkg::ProdW-1:0]         dt_r;
  logic [rws_pkg::ProdW-1:0]         acc_r;

  logic [rws_pkg::IdxW-1:0]          rd_idx_r, idx1_r, idx2_r;
  logic                              v1_r, v2_r;

  logic [rws_pkg::IdxW-1:0]          res_idx_r;
  logic                              res_status_r;

  logic                              out_valid_r;
  logic [rws_pkg::IdxW-1:0]          out_idx_r;
  logic                              out_status_r;

  logic                              accept;
  logic                              do_load;
  logic [rws_pkg::CntW-1:0]          cnt_m1;
  logic [rws_pkg::IdxW-1:0]          last_idx;
  logic signed [rws_pkg::FitW+7:0]   cl_prod;
  logic [rws_pkg::RawW-1:0]          shifted_total;
  logic [rws_pkg::ProdW-1:0]         dt_prod;
  logic [rws_pkg::FitW-1:0]          shifted_fit;
  logic [rws_pkg::AccW-1:0]          fit_x1000;
  logic                              hit;
  logic                              out_free;

  assign accept   = in_req.valid && in_req.ready;
  assign do_load  = accept && (in_req.command == rws_pkg::CMD_LOAD)
                    && (count_r < rws_pkg::CntW'(rws_pkg::MaxPop));
  assign cnt_m1   = count_r - rws_pkg::CntW'(1);
  assign last_idx = cnt_m1[rws_pkg::IdxW-1:0];

  // count times lowest is non-positive; the shifted total fits in TotW bits
  assign cl_prod       = $signed({1'b0, count_r}) * lowest_r;
  assign shifted_total = raw_r - cl_prod[rws_pkg::RawW-1:0];
  assign dt_prod       = draw_r * total_r;

  // fitness minus lowest lies in 0 .. 2^32-1; times 1000 = 1024 - 16 - 8
  assign shifted_fit = rdata_r - lowest_r;
  assign fit_x1000   = {shifted_fit, 10'b0} - {6'b0, shifted_fit, 4'b0}
                       - {7'b0, shifted_fit, 3'b0};

  assign hit      = (acc_r > dt_r) || (idx2_r == last_idx);
  assign out_free = !out_valid_r || out_res.ready;

  assign in_req.ready          = (state_r == rws_pkg::ST_IDLE);
  assign out_res.valid         = out_valid_r;
  assign out_res.selected_index = out_idx_r;
  assign out_res.status        = out_status_r;

  // fitness store: written on load, read one entry per cycle during the walk
  always_ff @(posedge clk) begin
    if (do_load) begin
      fit_mem[count_r[rws_pkg::IdxW-1:0]] <= in_req.fitness_value;
    end
    rdata_r <= fit_mem[rd_idx_r];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rws_pkg::ST_IDLE: begin
        if (accept && in_req.command == rws_pkg::CMD_DRAW) state_nxt = rws_pkg::ST_TOTAL;
      end
      rws_pkg::ST_TOTAL: state_nxt = rws_pkg::ST_SCALE;
      rws_pkg::ST_SCALE: begin
        state_nxt = (total_r == '0) ? rws_pkg::ST_EMIT : rws_pkg::ST_WALK;
      end
      rws_pkg::ST_WALK: begin
        if (v2_r && hit) state_nxt = rws_pkg::ST_EMIT;
      end
      rws_pkg::ST_EMIT: begin
        if (out_free) state_nxt = rws_pkg::ST_IDLE;
      end
      default: state_nxt = rws_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rws_pkg::ST_IDLE;
      count_r     <= '0;
      lowest_r    <= '0;
      raw_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (accept) begin
        case (in_req.command)
          rws_pkg::CMD_CLEAR: begin
            count_r  <= '0;
            lowest_r <= '0;
            raw_r    <= '0;
          end
          rws_pkg::CMD_LOAD: begin
            if (do_load) begin
              count_r <= count_r + rws_pkg::CntW'(1);
              raw_r   <= raw_r
                         + {{(rws_pkg::RawW-rws_pkg::FitW){in_req.fitness_value[rws_pkg::FitW-1]}},
                            in_req.fitness_value};
              if (in_req.fitness_value < lowest_r) lowest_r <= in_req.fitness_value;
            end
          end
          default: ;
        endcase
      end

      if (state_r == rws_pkg::ST_WALK) begin
        v1_r <= 1'b1;
        v2_r <= v1_r;
      end else begin
        v1_r <= 1'b0;
        v2_r <= 1'b0;
      end

      if (state_r == rws_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (accept) draw_r <= in_req.draw_value;

    if (state_r == rws_pkg::ST_TOTAL) total_r <= shifted_total[rws_pkg::TotW-1:0];

    if (state_r == rws_pkg::ST_SCALE) begin
      dt_r         <= dt_prod;
      acc_r        <= '0;
      rd_idx_r     <= '0;
      res_idx_r    <= '0;
      res_status_r <= rws_pkg::STATUS_EMPTY;
    end

    if (state_r == rws_pkg::ST_WALK) begin
      rd_idx_r <= rd_idx_r + rws_pkg::IdxW'(1);
      idx1_r   <= rd_idx_r;
      if (v1_r) begin
        acc_r  <= acc_r + rws_pkg::ProdW'(fit_x1000);
        idx2_r <= idx1_r;
      end
      if (v2_r && hit) begin
        res_idx_r    <= idx2_r;
        res_status_r <= rws_pkg::STATUS_OK;
      end
    end

    if (state_r == rws_pkg::ST_EMIT && out_free) begin
      out_idx_r    <= res_idx_r;
      out_status_r <= res_status_r;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rws_pkg::CntW'(rws_pkg::MaxPop))
    else $error("entry count beyond table depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rws_pkg::ST_WALK && v2_r) |-> (idx2_r <= last_idx))
    else $error("walk passed the last loaded entry");

  a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rws_pkg::ST_SCALE && total_r == '0) |=> (state_r == rws_pkg::ST_EMIT))
    else $error("zero total must not start a walk");

endmodule

>>> sim/tb_roulette_wheel_selector_unit.sv
`timescale 1ns / 100ps

module tb_roulette_wheel_selector_unit;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         RandomItems  = 1250;
  localparam int         HoldCycles   = 300;
  localparam int         CycleLimit   = 800_000;
  localparam int         DrainCycles  = 80;
  localparam int         NumDirected  = 27;

  typedef struct packed {
    logic [rws_pkg::IdxW-1:0] idx;
    rws_pkg::status_t         status;
  } pick_t;

  typedef struct {
    logic [1:0]                cmd;
    logic [rws_pkg::FitW-1:0]  fit;
    logic [rws_pkg::DrawW-1:0] draw;
    bit                        typed;
    logic [rws_pkg::IdxW-1:0]  idx;
    rws_pkg::status_t          status;
  } req_row_t;

  logic clk;
  logic rst_n;

  rws_in_if  in_req_if ();
  rws_out_if out_res_if ();

  roulette_wheel_selector_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req_if),
    .out_res (out_res_if)
  );

  // selector state as seen from the request stream
  logic signed [rws_pkg::FitW-1:0] fit_table [rws_pkg::MaxPop];
  int                              n_loaded;
  logic signed [rws_pkg::FitW-1:0] floor_fit;
  longint                          fit_sum;

  pick_t       pending_picks [$];
  int          mismatches  = 0;
  int unsigned cycle_count = 0;
  int          random_sent = 0;
  bit          gaps_on     = 1'b1;
  bit          hold_req    = 1'b0;
  bit          hold_fired  = 1'b0;

  // typed expectation for the request currently offered
  bit                       row_typed  = 1'b0;
  logic [rws_pkg::IdxW-1:0] row_idx    = '0;
  rws_pkg::status_t         row_status = rws_pkg::STATUS_OK;

  req_row_t directed_rows [NumDirected] = '{
    '{rws_pkg::CMD_DRAW,  32'h0000_0000, 10'd0,    1'b1, 6'd0, rws_pkg::STATUS_EMPTY},
    '{CMD_UNUSED,         32'hFFFF_FFFF, 10'd1023, 1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_DRAW,  32'h0000_0000, 10'd999,  1'b1, 6'd0, rws_pkg::STATUS_EMPTY},
    '{rws_pkg::CMD_LOAD,  32'h0000_0000, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_LOAD,  32'h0000_0000, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_DRAW,  32'h0000_0000, 10'd500,  1'b1, 6'd0, rws_pkg::STATUS_EMPTY},
    '{rws_pkg::CMD_CLEAR, 32'h0000_0000, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_LOAD,  32'h7FFF_FFFF, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_LOAD,  32'h8000_0000, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_DRAW,  32'h0000_0000, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_DRAW,  32'h0000_0000, 10'd999,  1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_DRAW,  32'h0000_0000, 10'd1023, 1'b1, 6'd1, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_LOAD,  32'h0000_0003, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_DRAW,  32'h0000_0000, 10'd1000, 1'b1, 6'd2, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 10'd1023, 1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_DRAW,  32'h0000_0000, 10'd1,    1'b1, 6'd0, rws_pkg::STATUS_EMPTY},
    '{rws_pkg::CMD_LOAD,  32'hFFFF_FFFB, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_LOAD,  32'hFFFF_FFFB, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_DRAW,  32'h0000_0000, 10'd250,  1'b1, 6'd0, rws_pkg::STATUS_EMPTY},
    '{rws_pkg::CMD_CLEAR, 32'h0000_0000, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_LOAD,  32'h0001_0000, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_LOAD,  32'h0002_0000, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_LOAD,  32'h0000_0000, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_DRAW,  32'h0000_0000, 10'd333,  1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_DRAW,  32'h0000_0000, 10'd334,  1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_DRAW,  32'h0000_0000, 10'd999,  1'b0, 6'd0, rws_pkg::STATUS_OK},
    '{rws_pkg::CMD_CLEAR, 32'h0000_0000, 10'd0,    1'b0, 6'd0, rws_pkg::STATUS_OK}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Apply one request to the selector state; a draw yields a pick.
  function automatic void selector_step(input logic [1:0] cmd,
                                        input logic signed [rws_pkg::FitW-1:0] fit,
                                        input logic [rws_pkg::DrawW-1:0] draw,
                                        output bit has_pick,
                                        output logic [rws_pkg::IdxW-1:0] idx,
                                        output rws_pkg::status_t st);
    longint span;
    longint target;
    longint run;
    int     chosen;
    bit     found;
    has_pick = 1'b0;
    idx      = '0;
    st       = rws_pkg::STATUS_OK;
    case (cmd)
      rws_pkg::CMD_CLEAR: begin
        n_loaded  = 0;
        floor_fit = '0;
        fit_sum   = 0;
      end
      rws_pkg::CMD_LOAD: begin
        // drop loads into a full table
        if (n_loaded < rws_pkg::MaxPop) begin
          fit_table[n_loaded] = fit;
          n_loaded++;
          if (fit < floor_fit) floor_fit = fit;
          fit_sum += longint'(fit);
        end
      end
      rws_pkg::CMD_DRAW: begin
        has_pick = 1'b1;
        span = fit_sum - longint'(n_loaded) * longint'(floor_fit);
        if (n_loaded == 0 || span == 0) begin
          st = rws_pkg::STATUS_EMPTY;
        end else begin
          target = longint'(draw) * span;
          chosen = n_loaded - 1;
          run    = 0;
          found  = 1'b0;
          for (int i = 0; i < n_loaded; i++) begin
            run += longint'(fit_table[i]) - longint'(floor_fit);
            if (!found && run * 1000 > target) begin
              chosen = i;
              found  = 1'b1;
            end
          end
          idx = chosen[rws_pkg::IdxW-1:0];
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [rws_pkg::FitW-1:0] pick_fitness(input int mode);
    logic [rws_pkg::FitW-1:0] v;
    case (mode)
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h0010_0000);
      2: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      default: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
    endcase
    return v;
  endfunction

  // Check results first, then account for the request taken at the same edge.
  always @(posedge clk) begin : monitor
    pick_t                    want;
    bit                       has_pick;
    logic [rws_pkg::IdxW-1:0] p_idx;
    rws_pkg::status_t         p_st;
    if (rst_n) begin
      if (out_res_if.valid && out_res_if.ready) begin
        if (pending_picks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result idx %0d status %0d with no draw pending",
                     $time, out_res_if.selected_index, out_res_if.status);
        end else begin
          want = pending_picks.pop_front();
          if (out_res_if.selected_index != want.idx || out_res_if.status != want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: pick mismatch: expected idx %0d status %0d, got idx %0d status %0d",
                       $time, want.idx, want.status,
                       out_res_if.selected_index, out_res_if.status);
          end
        end
      end
      if (in_req_if.valid && in_req_if.ready) begin
        selector_step(in_req_if.command, in_req_if.fitness_value, in_req_if.draw_value,
                      has_pick, p_idx, p_st);
        if (has_pick) begin
          if (row_typed) pending_picks.push_back('{row_idx, row_status});
          else           pending_picks.push_back('{p_idx, p_st});
        end
      end
    end
  end

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    out_res_if.ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        for (int c = 0; c < HoldCycles; c++) begin
          out_res_if.ready <= 1'b0;
          @(negedge clk);
        end
        hold_req = 1'b0;
      end
      out_res_if.ready <= gaps_on ? ($urandom_range(0, 99) >= 26) : 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [1:0] cmd, input logic [rws_pkg::FitW-1:0] fit,
                              input logic [rws_pkg::DrawW-1:0] draw, input bit typed,
                              input logic [rws_pkg::IdxW-1:0] idx,
                              input rws_pkg::status_t st);
    while (gaps_on && $urandom_range(0, 99) < 26) begin
      in_req_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_req_if.valid         <= 1'b1;
    in_req_if.command       <= cmd;
    in_req_if.fitness_value <= fit;
    in_req_if.draw_value    <= draw;
    row_typed  = typed;
    row_idx    = idx;
    row_status = st;
    do @(posedge clk); while (!in_req_if.ready);
    @(negedge clk);
  endtask

  task automatic send_random(input logic [1:0] cmd, input logic [rws_pkg::FitW-1:0] fit,
                             input logic [rws_pkg::DrawW-1:0] draw);
    send_request(cmd, fit, draw, 1'b0, '0, rws_pkg::STATUS_OK);
    if (cmd != CMD_UNUSED) random_sent++;
    gaps_on = !(random_sent >= 700 && random_sent < 900);
    if (random_sent >= 200 && !hold_fired) begin
      hold_req   = 1'b1;
      hold_fired = 1'b1;
    end
  endtask

  function automatic logic [rws_pkg::DrawW-1:0] pick_draw();
    if ($urandom_range(0, 9) == 0) return rws_pkg::DrawW'($urandom_range(1000, 1023));
    return rws_pkg::DrawW'($urandom_range(0, 999));
  endfunction

  initial begin
    int                       shape;
    int                       n_load;
    int                       n_draw;
    int                       mode;
    logic [rws_pkg::FitW-1:0] same_fit;
    rst_n                   = 1'b0;
    in_req_if.valid         = 1'b0;
    in_req_if.command       = rws_pkg::CMD_CLEAR;
    in_req_if.fitness_value = '0;
    in_req_if.draw_value    = '0;
    n_loaded                = 0;
    floor_fit               = '0;
    fit_sum                 = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r])
      send_request(directed_rows[r].cmd, directed_rows[r].fit, directed_rows[r].draw,
                   directed_rows[r].typed, directed_rows[r].idx, directed_rows[r].status);

    while (random_sent < RandomItems) begin
      shape = $urandom_range(0, 99);
      if (shape < 8) begin
        send_random(2'($urandom_range(0, 3)), $urandom,
                    rws_pkg::DrawW'($urandom_range(0, 1023)));
      end else begin
        if ($urandom_range(0, 99) < 85)
          send_random(rws_pkg::CMD_CLEAR, $urandom, rws_pkg::DrawW'($urandom_range(0, 1023)));
        n_load   = ($urandom_range(0, 99) < 8) ? $urandom_range(60, 70) : $urandom_range(1, 12);
        mode     = $urandom_range(0, 4);
        same_fit = pick_fitness(2);
        for (int k = 0; k < n_load; k++) begin
          send_random(rws_pkg::CMD_LOAD, (mode == 3) ? same_fit : pick_fitness(mode),
                      rws_pkg::DrawW'($urandom_range(0, 1023)));
          if ($urandom_range(0, 9) == 0) send_random(rws_pkg::CMD_DRAW, $urandom, pick_draw());
        end
        n_draw = $urandom_range(1, 6);
        for (int k = 0; k < n_draw; k++) send_random(rws_pkg::CMD_DRAW, $urandom, pick_draw());
      end
    end
    in_req_if.valid <= 1'b0;

    while (pending_picks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/rws_pkg.sv
design/rws_if.sv
design/roulette_wheel_selector_unit.sv
sim/tb_roulette_wheel_selector_unit.sv
